### design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the sorted priority queue
// Entry layout, command bundle, opcode and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DATA_W = 32;
  localparam int PRIO_W = 16;
  localparam int FILL_W = 8;

  // opcodes of an input beat
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // one stored entry of the chain
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] data;
    logic        [PRIO_W-1:0] prio;
  } entry_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic signed [DATA_W-1:0] data;
    logic        [PRIO_W-1:0] prio;
  } cell_cmd_t;

endpackage

### design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one compare-and-shift cell of the sorted chain
// Holds one entry; on enqueue keeps, takes the new entry or takes the left
// neighbor; on dequeue takes the right neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::cell_cmd_t cmd,
  input  spq_pkg::entry_t    left_entry,
  input  logic               left_keep,
  input  spq_pkg::entry_t    right_entry,
  output spq_pkg::entry_t    cur_entry,
  output logic               keep
);
  import spq_pkg::*;

  logic                     valid_r, valid_nxt;
  logic signed [DATA_W-1:0] data_r, data_nxt;
  logic        [PRIO_W-1:0] prio_r, prio_nxt;

  // stay put when occupied by an entry that is served no later than the new one
  assign keep = valid_r && (prio_r <= cmd.prio);

  // select the next content of this cell
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    prio_nxt  = prio_r;
    if (cmd.enq && !keep) begin
      if (left_keep) begin
        valid_nxt = 1'b1;
        data_nxt  = cmd.data;
        prio_nxt  = cmd.prio;
      end else begin
        valid_nxt = left_entry.valid;
        data_nxt  = left_entry.data;
        prio_nxt  = left_entry.prio;
      end
    end else if (cmd.deq) begin
      valid_nxt = right_entry.valid;
      data_nxt  = right_entry.data;
      prio_nxt  = right_entry.prio;
    end
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload and priority
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

  assign cur_entry = '{valid: valid_r, data: data_r, prio: prio_r};

endmodule

### design/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: systolic sorted priority queue
// Chain of DEPTH compare-and-shift cells kept sorted by priority, head first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_opcode, in_data_in and in_priority_in and raise
//   start; the beat is taken at a rising edge where start is high and busy
//   is low. busy stays low, so a new beat can be taken in every cycle.
//   in_opcode selects enqueue (store data with priority) or dequeue (remove
//   the entry with the lowest priority number; equal priorities leave in
//   arrival order).
//   Result channel: one result per beat, on the out_ ports for exactly one
//   cycle with out_valid high, in the cycle after the beat is taken. The
//   receiver cannot stall; results are never held back.
//   Throughput: one operation per cycle. Every cell compares its priority
//   with the new one and moves its entry one place in the same cycle, so the
//   whole chain updates at once.
//   Full enqueue is dropped with status full; empty dequeue reports status
//   empty. fill_count shows the entry count modulo 256.
//   Reset: synchronous, active low; clears all occupancy flags and the count,
//   so the queue starts empty with no clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int DEPTH = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_opcode,
  input  logic signed [spq_pkg::DATA_W-1:0] in_data_in,
  input  logic        [spq_pkg::PRIO_W-1:0] in_priority_in,
  output logic                             out_valid,
  output logic signed [spq_pkg::DATA_W-1:0] out_data_out,
  output logic                             out_data_valid,
  output logic        [1:0]                out_status,
  output logic        [spq_pkg::FILL_W-1:0] out_fill_count,
  output logic                             out_is_empty,
  output logic                             out_is_full
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                     accept;
  logic                     q_full, q_empty;
  logic [CNT_W-1:0]         count_r, count_nxt;
  cell_cmd_t                cmd;
  entry_t                   cells   [DEPTH];
  logic                     keeps   [DEPTH];
  logic [DEPTH-1:0]         occ;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_data_r, out_data_nxt;
  logic                     out_dvalid_r, out_dvalid_nxt;
  logic [1:0]               out_status_r, out_status_nxt;
  logic [FILL_W-1:0]        out_fill_r;
  logic                     out_empty_r, out_full_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign q_full  = (count_r == CNT_W'(DEPTH));
  assign q_empty = (count_r == '0);

  // decode the beat into the broadcast command
  always_comb begin
    cmd.enq  = accept && (in_opcode == OP_ENQ) && !q_full;
    cmd.deq  = accept && (in_opcode == OP_DEQ) && !q_empty;
    cmd.data = in_data_in;
    cmd.prio = in_priority_in;
  end

  // build the chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_k;

    if (i == 0) begin : g_head
      assign left_e = '0;
      assign left_k = 1'b1;
    end else begin : g_mid
      assign left_e = cells[i-1];
      assign left_k = keeps[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = cells[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_entry  (left_e),
      .left_keep   (left_k),
      .right_entry (right_e),
      .cur_entry   (cells[i]),
      .keep        (keeps[i])
    );

    assign occ[i] = cells[i].valid;
  end

  // advance the entry count
  always_comb begin
    count_nxt = count_r;
    if (cmd.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.deq) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // form the result fields
  always_comb begin
    out_data_nxt   = '0;
    out_dvalid_nxt = 1'b0;
    out_status_nxt = ST_OK;
    if (in_opcode == OP_ENQ) begin
      if (q_full) begin
        out_status_nxt = ST_FULL;
      end
    end else if (q_empty) begin
      out_status_nxt = ST_EMPTY;
    end else begin
      out_data_nxt   = cells[0].data;
      out_dvalid_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r   <= out_data_nxt;
      out_dvalid_r <= out_dvalid_nxt;
      out_status_r <= out_status_nxt;
      out_fill_r   <= FILL_W'(count_nxt);
      out_empty_r  <= (count_nxt == '0);
      out_full_r   <= (count_nxt == CNT_W'(DEPTH));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_out   = out_data_r;
  assign out_data_valid = out_dvalid_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_r;
  assign out_is_empty   = out_empty_r;
  assign out_is_full    = out_full_r;

  // the count tracks the occupied cells
  a_count_occ: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(occ) == int'(count_r))
    else $error("entry count differs from occupied cells");

  // the second cell is occupied only when the head cell is
  a_occ_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    occ[1] |-> occ[0])
    else $error("hole at the head of the chain");

  // the two front entries stay in order
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    occ[1] |-> (cells[0].prio <= cells[1].prio))
    else $error("head entries out of order");

  // one result follows each accepted beat
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted beat without result");

  // a dequeued payload only comes with status ok
  a_dvalid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data_valid) |-> (out_status == ST_OK))
    else $error("dequeued payload with error status");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: sorted priority queue checker
// Drives enqueue and dequeue beats into the queue, predicts each result from
// a shadow copy of the sorted entries, and checks every result beat field by
// field. A short directed sequence is followed by fill and drain sweeps with
// random content.
// ----------------------------------------------------------------------------
module testbench;
  import spq_pkg::*;

  localparam int QDEPTH         = 128;
  localparam int DIRECTED_ROWS  = 20;
  localparam int RANDOM_OPS     = 500;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 200;
  localparam int REPORT_LIMIT   = 10;

  // one result beat as seen on the out_ ports
  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic                     data_valid;
    logic        [1:0]        status;
    logic        [FILL_W-1:0] fill_count;
    logic                     is_empty;
    logic                     is_full;
  } queue_result_t;

  // one directed beat; typed rows carry their result, others use the predictor
  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] payload;
    logic        [PRIO_W-1:0] prio;
    logic                     typed;
    queue_result_t            result;
  } directed_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_opcode = OP_ENQ;
  logic signed [DATA_W-1:0]  in_data_in = '0;
  logic        [PRIO_W-1:0]  in_priority_in = '0;
  logic                      out_valid;
  logic signed [DATA_W-1:0]  out_data_out;
  logic                      out_data_valid;
  logic        [1:0]         out_status;
  logic        [FILL_W-1:0]  out_fill_count;
  logic                      out_is_empty;
  logic                      out_is_full;

  entry_t        shadow_queue[$];
  queue_result_t pending_results[$];

  int failures      = 0;
  int results_seen  = 0;
  int enq_beats     = 0;
  int deq_beats     = 0;
  int full_drops    = 0;
  int empty_deqs    = 0;
  int times_full    = 0;
  int stalled_cycles = 0;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // dequeue on empty right after reset
    '{OP_DEQ, 32'sh0000_0000, 16'h0000, 1'b1,
      '{32'sh0, 1'b0, ST_EMPTY, 8'd0, 1'b1, 1'b0}},
    // extremes of payload and priority
    '{OP_ENQ, 32'sh7FFF_FFFF, 16'hFFFF, 1'b1,
      '{32'sh0, 1'b0, ST_OK, 8'd1, 1'b0, 1'b0}},
    '{OP_ENQ, 32'sh8000_0000, 16'h0000, 1'b1,
      '{32'sh0, 1'b0, ST_OK, 8'd2, 1'b0, 1'b0}},
    // ties at both ends keep arrival order
    '{OP_ENQ, 32'sh0000_0000, 16'hFFFF, 1'b0, '0},
    '{OP_ENQ, 32'shFFFF_FFFF, 16'h0000, 1'b0, '0},
    '{OP_ENQ, 32'sh5555_5555, 16'h5555, 1'b0, '0},
    '{OP_ENQ, 32'shAAAA_AAAA, 16'hAAAA, 1'b0, '0},
    '{OP_ENQ, 32'sh0000_0001, 16'h0001, 1'b0, '0},
    // dequeue with all-ones payload and priority, which it ignores
    '{OP_DEQ, 32'shFFFF_FFFF, 16'hFFFF, 1'b0, '0},
    '{OP_ENQ, 32'sh0000_0002, 16'h0000, 1'b0, '0},
    // drain everything
    '{OP_DEQ, 32'sh0000_0000, 16'h0000, 1'b0, '0},
    '{OP_DEQ, 32'sh0000_0000, 16'h0000, 1'b0, '0},
    '{OP_DEQ, 32'sh0000_0000, 16'h0000, 1'b0, '0},
    '{OP_DEQ, 32'sh0000_0000, 16'h0000, 1'b0, '0},
    '{OP_DEQ, 32'sh0000_0000, 16'h0000, 1'b0, '0},
    '{OP_DEQ, 32'sh0000_0000, 16'h0000, 1'b0, '0},
    '{OP_DEQ, 32'sh0000_0000, 16'h0000, 1'b0, '0},
    // empty again
    '{OP_DEQ, 32'sh0000_0000, 16'h0000, 1'b1,
      '{32'sh0, 1'b0, ST_EMPTY, 8'd0, 1'b1, 1'b0}},
    // single entry in and out
    '{OP_ENQ, 32'sh1234_5678, 16'h8000, 1'b1,
      '{32'sh0, 1'b0, ST_OK, 8'd1, 1'b0, 1'b0}},
    '{OP_DEQ, 32'sh0000_0000, 16'h0000, 1'b1,
      '{32'sh1234_5678, 1'b1, ST_OK, 8'd0, 1'b1, 1'b0}}
  };

  sorted_priority_queue #(
    .DEPTH(QDEPTH)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_data_in    (in_data_in),
    .in_priority_in(in_priority_in),
    .out_valid     (out_valid),
    .out_data_out  (out_data_out),
    .out_data_valid(out_data_valid),
    .out_status    (out_status),
    .out_fill_count(out_fill_count),
    .out_is_empty  (out_is_empty),
    .out_is_full   (out_is_full)
  );

  always #5 clk = ~clk;

  // apply one operation to the shadow queue and return the result it gives
  function automatic queue_result_t predict_queue_op(input logic op,
      input logic signed [DATA_W-1:0] payload, input logic [PRIO_W-1:0] prio);
    queue_result_t r;
    entry_t        slot;
    int            pos;
    int            n;
    r = '0;
    if (op == OP_ENQ) begin
      if (shadow_queue.size() >= QDEPTH) begin
        r.status = ST_FULL;
      end else begin
        slot.valid = 1'b1;
        slot.data  = payload;
        slot.prio  = prio;
        // go behind every entry of lower or equal priority
        pos = shadow_queue.size();
        while (pos > 0 && prio < shadow_queue[pos-1].prio) pos--;
        shadow_queue.insert(pos, slot);
      end
    end else if (shadow_queue.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      slot = shadow_queue.pop_front();
      r.data_out   = slot.data;
      r.data_valid = 1'b1;
    end
    n = shadow_queue.size();
    r.fill_count = n[FILL_W-1:0];
    r.is_empty   = (n == 0);
    r.is_full    = (n >= QDEPTH);
    return r;
  endfunction

  // drive one beat, hold it until taken, then queue its result
  task automatic send_op(input logic op, input logic signed [DATA_W-1:0] payload,
      input logic [PRIO_W-1:0] prio, input logic typed, input queue_result_t typed_result);
    queue_result_t predicted;
    start          <= 1'b1;
    in_opcode      <= op;
    in_data_in     <= payload;
    in_priority_in <= prio;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predicted = predict_queue_op(op, payload, prio);
    pending_results.push_back(typed ? typed_result : predicted);
    if (op == OP_ENQ) enq_beats++;
    else deq_beats++;
    if (predicted.status == ST_FULL) full_drops++;
    if (predicted.status == ST_EMPTY) empty_deqs++;
    if (op == OP_ENQ && predicted.status == ST_OK && predicted.is_full) times_full++;
  endtask

  // drop start for a while and wiggle the inputs the block should ignore
  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) begin
      in_opcode      <= 1'($urandom);
      in_data_in     <= $urandom;
      in_priority_in <= 16'($urandom);
      @(posedge clk);
    end
  endtask

  // alternate fill and drain sweeps, each running past the full or empty edge
  task automatic run_random_ops(input int n_ops);
    logic              filling;
    logic              idle_ok;
    int                edge_hits;
    int                edge_goal;
    int                pick;
    logic              op;
    logic [PRIO_W-1:0] prio;
    filling   = 1'b1;
    idle_ok   = 1'b1;
    edge_hits = 0;
    edge_goal = $urandom_range(1, 4);
    for (int i = 0; i < n_ops; i++) begin
      if (i % 40 == 0) idle_ok = (i < n_ops - 120) && ($urandom_range(0, 3) != 0);
      if (edge_hits >= edge_goal) begin
        filling   = !filling;
        edge_hits = 0;
        edge_goal = $urandom_range(1, 4);
      end
      if ($urandom_range(0, 99) < 88) op = filling ? OP_ENQ : OP_DEQ;
      else op = filling ? OP_DEQ : OP_ENQ;
      if (filling && op == OP_ENQ && shadow_queue.size() >= QDEPTH) edge_hits++;
      if (!filling && op == OP_DEQ && shadow_queue.size() == 0) edge_hits++;
      // narrow priorities make ties, the rest spread over the range or sit at its ends
      pick = $urandom_range(0, 9);
      if (pick < 4) prio = PRIO_W'($urandom_range(0, 7));
      else if (pick < 8) prio = 16'($urandom);
      else prio = pick[0] ? 16'hFFFF : 16'h0000;
      send_op(op, $urandom, prio, 1'b0, '0);
      if (idle_ok && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 7));
    end
  endtask

  function automatic void check_field(input string field,
      input logic [DATA_W-1:0] want, input logic [DATA_W-1:0] got);
    if (got !== want) begin
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("%0t: result %0d %s mismatch: expected %h, got %h",
                 $realtime, results_seen, field, want, got);
    end
  endfunction

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    queue_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("%0t: result beat with nothing pending", $realtime);
      end else begin
        want = pending_results.pop_front();
        check_field("data_out",   want.data_out,   out_data_out);
        check_field("data_valid", DATA_W'(want.data_valid), DATA_W'(out_data_valid));
        check_field("status",     DATA_W'(want.status),     DATA_W'(out_status));
        check_field("fill_count", DATA_W'(want.fill_count), DATA_W'(out_fill_count));
        check_field("is_empty",   DATA_W'(want.is_empty),   DATA_W'(out_is_empty));
        check_field("is_full",    DATA_W'(want.is_full),    DATA_W'(out_is_full));
      end
      results_seen++;
    end
  end

  // stop the run when neither side moves a beat for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed rows
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_op(directed_rows[r].op, directed_rows[r].payload, directed_rows[r].prio,
              directed_rows[r].typed, directed_rows[r].result);
      if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 7));
    end

    run_random_ops(RANDOM_OPS);
    start <= 1'b0;

    // drain outstanding results, then let the pipe settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d beats: %0d enqueues, %0d dequeues, %0d results checked",
             enq_beats + deq_beats, enq_beats, deq_beats, results_seen);
    $display("queue hit capacity %0d times, %0d enqueues dropped, %0d dequeues on empty",
             times_full, full_drops, empty_deqs);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", failures, pending_results.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
sim/testbench.sv
